/* hw/rtl/tex_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tex_pkg
// Shared types and constants of the tick extender with time anchors.
// ----------------------------------------------------------------------------
package tex_pkg;

  localparam int MaxAnchors = 64;

  localparam logic [31:0] WRAP_LIMIT   = 32'h0fff_ffff;
  localparam logic [10:0] CHECK_PERIOD = 11'd1000;
  localparam logic [9:0]  SPAN_RESET   = 10'd100;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic [63:0] tick;
    logic [63:0] wall;
  } entry_t;

  typedef struct packed {
    logic rotate;
    logic store;
  } row_cmd_t;

  typedef struct packed {
    logic take_next;
    logic take_new;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/tex_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tex_cell
// One anchor slot: holds a tick and wall time pair, loads a new anchor or
// takes the pair of its right-hand neighbor.
// ----------------------------------------------------------------------------
module tex_cell (
  input  wire                 clk,
  input  tex_pkg::cell_ctrl_t ctrl,
  input  tex_pkg::entry_t     nbr,
  input  tex_pkg::entry_t     new_entry,
  output tex_pkg::entry_t     held
);
  import tex_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.take_new) begin
      held <= new_entry;
    end else if (ctrl.take_next) begin
      held <= nbr;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tex_row.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tex_row
// Row of anchor cells. A store appends at the fill count, or drops slot 1
// and shifts the upper slots down when full. A rotate moves every pair one
// slot toward the head, so a full turn presents each slot at the head once.
// ----------------------------------------------------------------------------
module tex_row #(
  parameter int N  = tex_pkg::MaxAnchors,
  parameter int CW = $clog2(N + 1)
) (
  input  wire               clk,
  input  tex_pkg::row_cmd_t cmd,
  input  wire [CW-1:0]      count,
  input  tex_pkg::entry_t   new_entry,
  output tex_pkg::entry_t   head
);
  import tex_pkg::*;

  entry_t     cells [N];
  cell_ctrl_t ctrl  [N];
  logic       full;

  assign full = (count >= CW'(N));
  assign head = cells[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      ctrl[i].take_new  = cmd.store && (full ? (i == N - 1) : (count == CW'(i)));
      ctrl[i].take_next = cmd.rotate ||
                          (cmd.store && full && (i >= 1) && (i <= N - 2));
    end

    tex_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .nbr       (cells[(i + 1) % N]),
      .new_entry (new_entry),
      .held      (cells[i])
    );
  end

endmodule
`default_nettype wire

/* hw/rtl/tick_extender_with_time_anchors.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tick_extender_with_time_anchors
// Extends a 32-bit millisecond counter to a 64-bit tick and maps ticks to
// wall time through a row of stored anchors.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A sample beat steps through EXT, TICK
// and SEED, then DRIFT and DIFF when the drift check runs (on the first
// sample and once per accumulated second), and ends in DONE. A query beat
// turns the anchor row one slot per cycle, once around the row, past the
// single compare and add unit at its head, then ends in DONE. The result
// sits in an output register, so the next beat is accepted while the
// previous result waits. A span write is taken at any time.
module tick_extender_with_time_anchors #(
  parameter int MAX_ANCHORS = tex_pkg::MaxAnchors
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [9:0]  cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         operation,
  input  wire  [31:0] raw_tick,
  input  wire  [63:0] system_time,
  input  wire  [63:0] query_tick,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] extended_tick,
  output logic [63:0] converted_time,
  output logic        anchor_added,
  output logic [6:0]  anchor_count
);
  import tex_pkg::*;

  localparam int CW = $clog2(MAX_ANCHORS + 1);
  localparam int KW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXT   = 4'd1;
  localparam logic [3:0] S_TICK  = 4'd2;
  localparam logic [3:0] S_SEED  = 4'd3;
  localparam logic [3:0] S_DRIFT = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]    state;
  logic [9:0]    span;
  logic [31:0]   last_raw;
  logic [31:0]   wrap_count;
  logic [63:0]   start_offset;
  logic [63:0]   current_tick;
  logic [10:0]   check_accum;
  logic          checked_once;
  logic          seeded;
  logic [63:0]   anchor_time;
  logic [63:0]   anchor_tick;
  logic [CW-1:0] entries;
  logic          do_check;
  logic          added;
  logic [KW-1:0] k;

  logic          op;
  logic [31:0]   raw;
  logic [63:0]   now;
  logic [63:0]   q;
  logic [63:0]   ext_raw;
  logic [63:0]   drift;
  logic          back;
  logic [63:0]   conv;

  logic          raw_lower;
  logic [31:0]   raw_drop;
  logic          is_wrap;
  logic [31:0]   raw_eff;
  logic [31:0]   wrap_new;
  logic [63:0]   ext_raw_c;
  logic [63:0]   tick_c;
  logic [10:0]   accum_sum;
  logic          do_check_c;
  logic [63:0]   diff_c;
  logic          far;
  logic          drift_store;
  logic          hit;
  logic [63:0]   conv_c;
  logic [63:0]   final_conv;
  logic          out_free;
  logic          accept;
  row_cmd_t      cmd;
  entry_t        new_entry;
  entry_t        head;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    raw_lower   = (last_raw > raw);
    raw_drop    = last_raw - raw;
    is_wrap     = raw_lower && (raw_drop >= WRAP_LIMIT);
    raw_eff     = (raw_lower && !is_wrap) ? last_raw : raw;
    wrap_new    = wrap_count + {31'd0, is_wrap};
    ext_raw_c   = {wrap_new, raw_eff};
    tick_c      = ext_raw - start_offset + 64'd1;
    accum_sum   = check_accum + {1'b0, span};
    do_check_c  = (accum_sum >= CHECK_PERIOD) || !checked_once;
    diff_c      = (drift > current_tick) ? (drift - current_tick) : (current_tick - drift);
    far         = (diff_c >= {54'd0, span});
    drift_store = back || far;
    hit         = (CW'(k) < entries) && (head.tick <= q);
    conv_c      = head.wall + (q - head.tick);
    if (q == 64'd0) begin
      final_conv = 64'd0;
    end else if (conv == 64'd0) begin
      final_conv = 64'd1;
    end else begin
      final_conv = conv;
    end
  end

  always_comb begin
    cmd.rotate     = (state == S_SCAN);
    cmd.store      = ((state == S_SEED) && !seeded) ||
                     ((state == S_DIFF) && drift_store);
    new_entry.tick = current_tick;
    new_entry.wall = now;
  end

  tex_row #(
    .N  (MAX_ANCHORS),
    .CW (CW)
  ) u_row (
    .clk       (clk),
    .cmd       (cmd),
    .count     (entries),
    .new_entry (new_entry),
    .head      (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      span         <= SPAN_RESET;
      last_raw     <= '0;
      wrap_count   <= '0;
      start_offset <= '0;
      current_tick <= '0;
      check_accum  <= '0;
      checked_once <= 1'b0;
      seeded       <= 1'b0;
      anchor_time  <= '0;
      anchor_tick  <= '0;
      entries      <= '0;
      do_check     <= 1'b0;
      added        <= 1'b0;
      k            <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        span <= cfg_data;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.store && (entries < CW'(MAX_ANCHORS))) begin
        entries <= entries + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            added <= 1'b0;
            k     <= '0;
            state <= (operation == OP_QUERY) ? S_SCAN : S_EXT;
          end
        end
        S_EXT: begin
          last_raw   <= raw_eff;
          wrap_count <= wrap_new;
          if (start_offset == 64'd0) begin
            start_offset <= ext_raw_c;
          end
          state <= S_TICK;
        end
        S_TICK: begin
          current_tick <= tick_c;
          do_check     <= do_check_c;
          check_accum  <= do_check_c ? 11'd0 : accum_sum;
          checked_once <= checked_once || do_check_c;
          state        <= S_SEED;
        end
        S_SEED: begin
          if (!seeded) begin
            seeded      <= 1'b1;
            anchor_tick <= current_tick;
            anchor_time <= now;
            added       <= 1'b1;
          end
          state <= do_check ? S_DRIFT : S_DONE;
        end
        S_DRIFT: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          if (drift_store) begin
            anchor_tick <= current_tick;
            anchor_time <= now;
            added       <= 1'b1;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          k <= k + KW'(1);
          if (k == KW'(MAX_ANCHORS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= operation;
      raw  <= raw_tick;
      now  <= system_time;
      q    <= query_tick;
      conv <= '0;
    end
    if (state == S_EXT) begin
      ext_raw <= ext_raw_c;
    end
    if (state == S_DRIFT) begin
      drift <= now - anchor_time + anchor_tick;
      back  <= (now < anchor_time);
    end
    if ((state == S_SCAN) && hit) begin
      conv <= conv_c;
    end
    if ((state == S_DONE) && out_free) begin
      extended_tick  <= current_tick;
      converted_time <= (op == OP_QUERY) ? final_conv : 64'd0;
      anchor_added   <= added;
      anchor_count   <= 7'(entries);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tex_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tex_checker
// Port-level checks of the tick extender, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tex_checker (
  input wire        clk,
  input wire        rst,
  input wire        cfg_valid,
  input wire        cfg_ready,
  input wire [9:0]  cfg_data,
  input wire        in_valid,
  input wire        in_ready,
  input wire        operation,
  input wire [31:0] raw_tick,
  input wire [63:0] system_time,
  input wire [63:0] query_tick,
  input wire        out_valid,
  input wire        out_ready,
  input wire [63:0] extended_tick,
  input wire [63:0] converted_time,
  input wire        anchor_added,
  input wire [6:0]  anchor_count
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(extended_tick) &&
      $stable(converted_time) && $stable(anchor_added) && $stable(anchor_count))
    else $error("result beat changed while stalled");

  // Only a sample stores an anchor, and a sample reports no converted time.
  a_anchor_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && anchor_added |-> converted_time == 64'd0)
    else $error("anchor reported on a query result");

  // No result beat is valid in the cycle after reset.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // The block takes no new item in the cycle after accepting one.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted back to back");

endmodule

bind tick_extender_with_time_anchors tex_checker u_tex_checker (.*);
`default_nettype wire
